// ===== sv/gdad_pkg.sv =====
`default_nettype none

package gdad_pkg;

    localparam int OFFSET_WIDTH = 20;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;

    // day count accumulator, wide enough for a count plus any offset
    localparam int ACC_W = (OFFSET_WIDTH + 2 > 24) ? OFFSET_WIDTH + 2 : 24;

    localparam int YEAR_MAX    = 9999;
    localparam int CYCLE_YEARS = 400;
    localparam int DAYS_CYCLE  = 146097;
    localparam int LAST_COUNT  = 3652424;
    localparam int DAYS_YEAR   = 365;
    localparam int MONTHS      = 12;

    // input tdata layout, lowest bit first
    localparam int IN_YA_LO  = 0;
    localparam int IN_MA_LO  = IN_YA_LO + YEAR_W;
    localparam int IN_DA_LO  = IN_MA_LO + MONTH_W;
    localparam int IN_YB_LO  = IN_DA_LO + DAY_W;
    localparam int IN_MB_LO  = IN_YB_LO + YEAR_W;
    localparam int IN_DB_LO  = IN_MB_LO + MONTH_W;
    localparam int IN_OFF_LO = IN_DB_LO + DAY_W;
    localparam int IN_BITS   = IN_OFF_LO + OFFSET_WIDTH;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_YR_LO   = 0;
    localparam int OUT_MO_LO   = OUT_YR_LO + YEAR_W;
    localparam int OUT_DY_LO   = OUT_MO_LO + MONTH_W;
    localparam int OUT_DIFF_LO = OUT_DY_LO + DAY_W;
    localparam int OUT_GT      = OUT_DIFF_LO + DIFF_W;
    localparam int OUT_LT      = OUT_GT + 1;
    localparam int OUT_EQ      = OUT_LT + 1;
    localparam int OUT_BITS    = OUT_EQ + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_Y400  = 10'b00_0000_0010,
        S_Y1    = 10'b00_0000_0100,
        S_MON   = 10'b00_0000_1000,
        S_OFS   = 10'b00_0001_0000,
        S_CLAMP = 10'b00_0010_0000,
        S_C400  = 10'b00_0100_0000,
        S_C1    = 10'b00_1000_0000,
        S_CM    = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] mo,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        case (mo)
            MON_FEB: n = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gregorian_date_add_diff_core.sv =====
`default_nettype none

// Gregorian date add / difference core. Each request (op in tuser) either adds a
// signed day offset to date A (op 0) or returns the signed day count A minus B
// with order flags (op 1); invalid in the result tuser flags a bad input date or
// a result saturated to 0000-01-01 or 9999-12-31. All work runs through one
// shared adder on a day count accumulator, stepped by a sequencer: a date is
// turned into a day count by walking 400-year cycles, then single years, then
// months, and a count is turned back the same way. A date rejected outright
// skips the walks; otherwise the year walk covers up to 399 years per
// conversion, and op 0 makes two conversions, op 1 two. The input is not
// ready while an item is in work; a finished result sits in an output
// register, so the next request can be taken while it waits.
module gregorian_date_add_diff_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // year_a, month_a, day_a, year_b, month_b, day_b, offset, zero pad
    input  wire logic [gdad_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // op
    input  wire logic [0:0]                         i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // res_year, res_month, res_day, difference, greater, less, equal, zero pad
    output logic [gdad_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // invalid
    output logic [0:0]                              o_m_tuser
);

    localparam int ACC_W = gdad_pkg::ACC_W;
    localparam int YW    = gdad_pkg::YEAR_W;
    localparam int MW    = gdad_pkg::MONTH_W;
    localparam int DW    = gdad_pkg::DAY_W;
    localparam int OW    = gdad_pkg::OFFSET_WIDTH;

    gdad_pkg::t_state r_state, n_state;

    logic                 r_op;
    logic [YW-1:0]        r_yb;
    logic [MW-1:0]        r_ma, r_mb;
    logic [DW-1:0]        r_da, r_db;
    logic signed [OW-1:0] r_off;
    logic                 r_side, n_side;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [YW-1:0]        r_cnt, n_cnt;
    logic [6:0]           r_m100, n_m100;
    logic [8:0]           r_m400, n_m400;
    logic [MW-1:0]        r_mo, n_mo;
    logic [DW-1:0]        r_day, n_day;
    logic                 r_inv, n_inv;
    logic                 r_conv, n_conv;

    logic                             r_o_valid;
    logic [gdad_pkg::OUT_TDATA_W-1:0] r_o_data;
    logic                             r_o_inv;

    logic                 s_accept;
    logic                 leap;
    logic [MW-1:0]        cur_m;
    logic [DW-1:0]        cur_d;
    logic [DW-1:0]        dim_cur;
    logic [8:0]           days_year;
    logic [ACC_W-1:0]     alu_mag;
    logic [ACC_W-1:0]     alu_b;
    logic [ACC_W-1:0]     alu;
    logic                 alu_neg;
    logic [6:0]           m100_inc;
    logic [8:0]           m400_inc;
    logic                 in_op;
    logic [YW-1:0]        in_ya, in_yb;
    logic [MW-1:0]        in_ma, in_mb;
    logic [DW-1:0]        in_da, in_db;
    logic                 bad_a, bad_b;
    logic                 out_free;
    logic                 diff_ok;
    logic [gdad_pkg::OUT_TDATA_W-1:0] fin_data;

    assign o_s_tready = (r_state == gdad_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_o_valid || i_m_tready;

    assign in_op = i_s_tuser[0];
    assign in_ya = i_s_tdata[gdad_pkg::IN_YA_LO +: YW];
    assign in_ma = i_s_tdata[gdad_pkg::IN_MA_LO +: MW];
    assign in_da = i_s_tdata[gdad_pkg::IN_DA_LO +: DW];
    assign in_yb = i_s_tdata[gdad_pkg::IN_YB_LO +: YW];
    assign in_mb = i_s_tdata[gdad_pkg::IN_MB_LO +: MW];
    assign in_db = i_s_tdata[gdad_pkg::IN_DB_LO +: DW];

    // checks that need no leap year; day against month length comes after the walk
    assign bad_a = (in_ya > YW'(gdad_pkg::YEAR_MAX)) || (in_ma == '0)
                || (in_ma > MW'(gdad_pkg::MONTHS)) || (in_da == '0);
    assign bad_b = (in_yb > YW'(gdad_pkg::YEAR_MAX)) || (in_mb == '0)
                || (in_mb > MW'(gdad_pkg::MONTHS)) || (in_db == '0);

    // position within the 400-year cycle tracks the leap rule
    assign leap = (r_m400 == '0) || ((r_m100 != '0) && (r_m100[1:0] == 2'b00));
    assign m100_inc = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
    assign m400_inc = (r_m400 == 9'(gdad_pkg::CYCLE_YEARS - 1)) ? 9'd0 : r_m400 + 9'd1;

    assign cur_m     = r_side ? r_mb : r_ma;
    assign cur_d     = r_side ? r_db : r_da;
    assign dim_cur   = gdad_pkg::f_month_days(r_mo, leap);
    assign days_year = 9'(gdad_pkg::DAYS_YEAR) + {8'd0, leap};

    // shared adder operand
    always_comb begin
        alu_mag = '0;
        alu_b   = '0;
        case (r_state)
            gdad_pkg::S_Y400: begin
                alu_mag = ACC_W'(gdad_pkg::DAYS_CYCLE);
                alu_b   = r_side ? -alu_mag : alu_mag;
            end
            gdad_pkg::S_Y1: begin
                alu_mag = {{(ACC_W-9){1'b0}}, days_year};
                alu_b   = r_side ? -alu_mag : alu_mag;
            end
            gdad_pkg::S_MON: begin
                if (r_mo < cur_m) begin
                    alu_mag = {{(ACC_W-DW){1'b0}}, dim_cur};
                end else begin
                    alu_mag = {{(ACC_W-DW){1'b0}}, cur_d - 5'd1};
                end
                alu_b = r_side ? -alu_mag : alu_mag;
            end
            gdad_pkg::S_OFS: begin
                alu_b = {{(ACC_W-OW){r_off[OW-1]}}, r_off};
            end
            gdad_pkg::S_CLAMP: begin
                alu_mag = ACC_W'(gdad_pkg::LAST_COUNT + 1);
                alu_b   = -alu_mag;
            end
            gdad_pkg::S_C400: begin
                alu_mag = ACC_W'(gdad_pkg::DAYS_CYCLE);
                alu_b   = -alu_mag;
            end
            gdad_pkg::S_C1: begin
                alu_mag = {{(ACC_W-9){1'b0}}, days_year};
                alu_b   = -alu_mag;
            end
            gdad_pkg::S_CM: begin
                alu_mag = {{(ACC_W-DW){1'b0}}, dim_cur};
                alu_b   = -alu_mag;
            end
            default: begin
                alu_mag = '0;
                alu_b   = '0;
            end
        endcase
    end

    assign alu     = r_acc + alu_b;
    assign alu_neg = alu[ACC_W-1];

    assign diff_ok = r_op && !r_inv;

    always_comb begin
        fin_data = '0;
        fin_data[gdad_pkg::OUT_YR_LO +: YW] = r_conv ? r_cnt : '0;
        fin_data[gdad_pkg::OUT_MO_LO +: MW] = r_conv ? r_mo : gdad_pkg::MON_JAN;
        fin_data[gdad_pkg::OUT_DY_LO +: DW] = r_conv ? r_day : 5'd1;
        fin_data[gdad_pkg::OUT_DIFF_LO +: gdad_pkg::DIFF_W] =
            diff_ok ? r_acc[gdad_pkg::DIFF_W-1:0] : '0;
        fin_data[gdad_pkg::OUT_GT] = diff_ok && !r_acc[ACC_W-1] && (r_acc != '0);
        fin_data[gdad_pkg::OUT_LT] = diff_ok && r_acc[ACC_W-1];
        fin_data[gdad_pkg::OUT_EQ] = diff_ok && (r_acc == '0);
    end

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_m100  = r_m100;
        n_m400  = r_m400;
        n_mo    = r_mo;
        n_day   = r_day;
        n_inv   = r_inv;
        n_conv  = r_conv;
        case (r_state)
            gdad_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_side = 1'b0;
                    n_acc  = '0;
                    n_cnt  = in_ya;
                    n_m100 = '0;
                    n_m400 = '0;
                    n_conv = 1'b0;
                    if (bad_a || (in_op && bad_b)) begin
                        n_inv   = 1'b1;
                        n_state = gdad_pkg::S_FIN;
                    end else begin
                        n_inv   = 1'b0;
                        n_state = gdad_pkg::S_Y400;
                    end
                end
            end
            gdad_pkg::S_Y400: begin
                if (r_cnt >= YW'(gdad_pkg::CYCLE_YEARS)) begin
                    n_acc = alu;
                    n_cnt = r_cnt - YW'(gdad_pkg::CYCLE_YEARS);
                end else begin
                    n_state = gdad_pkg::S_Y1;
                end
            end
            gdad_pkg::S_Y1: begin
                if (r_cnt != '0) begin
                    n_acc  = alu;
                    n_cnt  = r_cnt - YW'(1);
                    n_m100 = m100_inc;
                    n_m400 = m400_inc;
                end else begin
                    n_mo    = gdad_pkg::MON_JAN;
                    n_state = gdad_pkg::S_MON;
                end
            end
            gdad_pkg::S_MON: begin
                if (r_mo < cur_m) begin
                    n_acc = alu;
                    n_mo  = r_mo + MW'(1);
                end else if (cur_d > dim_cur) begin
                    n_inv   = 1'b1;
                    n_state = gdad_pkg::S_FIN;
                end else begin
                    n_acc = alu;
                    if (r_side) begin
                        n_state = gdad_pkg::S_FIN;
                    end else if (r_op) begin
                        // date b counts down from the count of a
                        n_side  = 1'b1;
                        n_cnt   = r_yb;
                        n_m100  = '0;
                        n_m400  = '0;
                        n_state = gdad_pkg::S_Y400;
                    end else begin
                        n_state = gdad_pkg::S_OFS;
                    end
                end
            end
            gdad_pkg::S_OFS: begin
                n_acc   = alu;
                n_state = gdad_pkg::S_CLAMP;
            end
            gdad_pkg::S_CLAMP: begin
                if (r_acc[ACC_W-1]) begin
                    n_acc = '0;
                    n_inv = 1'b1;
                end else if (!alu_neg) begin
                    n_acc = ACC_W'(gdad_pkg::LAST_COUNT);
                    n_inv = 1'b1;
                end
                n_conv  = 1'b1;
                n_cnt   = '0;
                n_m100  = '0;
                n_m400  = '0;
                n_state = gdad_pkg::S_C400;
            end
            gdad_pkg::S_C400: begin
                if (!alu_neg) begin
                    n_acc = alu;
                    n_cnt = r_cnt + YW'(gdad_pkg::CYCLE_YEARS);
                end else begin
                    n_state = gdad_pkg::S_C1;
                end
            end
            gdad_pkg::S_C1: begin
                if ((r_cnt != YW'(gdad_pkg::YEAR_MAX)) && !alu_neg) begin
                    n_acc  = alu;
                    n_cnt  = r_cnt + YW'(1);
                    n_m100 = m100_inc;
                    n_m400 = m400_inc;
                end else begin
                    n_mo    = gdad_pkg::MON_JAN;
                    n_state = gdad_pkg::S_CM;
                end
            end
            gdad_pkg::S_CM: begin
                if ((r_mo != gdad_pkg::MON_DEC) && !alu_neg) begin
                    n_acc = alu;
                    n_mo  = r_mo + MW'(1);
                end else begin
                    n_day   = r_acc[DW-1:0] + 5'd1;
                    n_state = gdad_pkg::S_FIN;
                end
            end
            gdad_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = gdad_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdad_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gdad_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == gdad_pkg::S_FIN) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= in_op;
            r_ma  <= in_ma;
            r_da  <= in_da;
            r_yb  <= in_yb;
            r_mb  <= in_mb;
            r_db  <= in_db;
            r_off <= i_s_tdata[gdad_pkg::IN_OFF_LO +: OW];
        end
        r_side <= n_side;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_m100 <= n_m100;
        r_m400 <= n_m400;
        r_mo   <= n_mo;
        r_day  <= n_day;
        r_inv  <= n_inv;
        r_conv <= n_conv;
        if ((r_state == gdad_pkg::S_FIN) && out_free) begin
            r_o_data <= fin_data;
            r_o_inv  <= r_inv;
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = r_o_data;
    assign o_m_tuser[0] = r_o_inv;

    a_one_order_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $countones(o_m_tdata[gdad_pkg::OUT_EQ:gdad_pkg::OUT_GT]) <= 1)
        else $error("more than one order flag set");

    a_flags_not_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[gdad_pkg::OUT_GT] || o_m_tdata[gdad_pkg::OUT_LT]
        || o_m_tdata[gdad_pkg::OUT_EQ]) |-> !o_m_tuser[0])
        else $error("order flag with invalid result");

    a_year_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdad_pkg::S_C1) |-> (r_cnt <= YW'(gdad_pkg::YEAR_MAX)))
        else $error("year walk beyond range");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != gdad_pkg::S_IDLE))
        else $error("request taken without starting work");

endmodule

`default_nettype wire

// ===== tb/gdad_tb_pkg.sv =====
`timescale 1ns / 1ps

package gdad_tb_pkg;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_DIFF = 1'b1
    } date_op_t;

    function automatic bit leap_year(longint y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    // m must be 1..12
    function automatic longint month_length(longint y, longint m);
        case (m)
            gdad_pkg::MON_FEB: begin
                return leap_year(y) ? 29 : 28;
            end
            gdad_pkg::MON_APR, gdad_pkg::MON_JUN, gdad_pkg::MON_SEP, gdad_pkg::MON_NOV: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

endpackage

// ===== tb/gregorian_date_add_diff_checker.sv =====
`timescale 1ns / 1ps

module gregorian_date_add_diff_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    // year_a, month_a, day_a, year_b, month_b, day_b, offset, zero pad
    input  logic [gdad_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // op
    input  logic [0:0]                           i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    // res_year, res_month, res_day, difference, greater, less, equal, zero pad
    input  logic [gdad_pkg::OUT_TDATA_W-1:0]     i_m_tdata,
    // invalid
    input  logic [0:0]                           i_m_tuser,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import gdad_pkg::*;
    import gdad_tb_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DIFF_W-1:0]  difference;
        logic               greater;
        logic               less;
        logic               equal;
        logic               invalid;
    } date_result_t;

    date_result_t expected_results[$];
    int           mismatch_count = 0;
    int           pending_count = 0;
    int           result_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // days from 0000-01-01 to the first of january of year y
    function automatic longint year_start(longint y);
        return y * DAYS_YEAR + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic bit date_ok(longint y, longint m, longint d);
        if (y > YEAR_MAX || m < 1 || m > MONTHS || d < 1) begin
            return 1'b0;
        end
        return d <= month_length(y, m);
    endfunction

    function automatic longint day_number(longint y, longint m, longint d);
        longint c;
        c = year_start(y);
        for (longint i = 1; i < m; i++) begin
            c += month_length(y, i);
        end
        return c + d - 1;
    endfunction

    function automatic void count_to_date(input longint c, output longint y,
                                          output longint m, output longint d);
        longint yr;
        longint mo;
        yr = c * CYCLE_YEARS / DAYS_CYCLE;
        while (yr < YEAR_MAX && year_start(yr + 1) <= c) yr++;
        while (yr > 0 && year_start(yr) > c) yr--;
        c -= year_start(yr);
        mo = 1;
        while (mo < MONTHS && c >= month_length(yr, mo)) begin
            c -= month_length(yr, mo);
            mo++;
        end
        y = yr;
        m = mo;
        d = c + 1;
    endfunction

    function automatic date_result_t predict_date_op(date_op_t op,
                                                     logic [IN_TDATA_W-1:0] word);
        longint                         ya, ma, da, yb, mb, db;
        longint                         ofs, cnt, last, diff, ry, rm, rd;
        logic signed [OFFSET_WIDTH-1:0] raw_ofs;
        date_result_t                   r;
        ya      = word[IN_YA_LO +: YEAR_W];
        ma      = word[IN_MA_LO +: MONTH_W];
        da      = word[IN_DA_LO +: DAY_W];
        yb      = word[IN_YB_LO +: YEAR_W];
        mb      = word[IN_MB_LO +: MONTH_W];
        db      = word[IN_DB_LO +: DAY_W];
        raw_ofs = word[IN_OFF_LO +: OFFSET_WIDTH];
        ofs     = raw_ofs;
        r       = '0;
        r.month = 1;
        r.day   = 1;
        if (op == OP_ADD) begin
            if (!date_ok(ya, ma, da)) begin
                r.invalid = 1'b1;
            end else begin
                last = year_start(YEAR_MAX + 1) - 1;
                cnt  = day_number(ya, ma, da) + ofs;
                // saturate at either end of the calendar
                if (cnt < 0) begin
                    cnt       = 0;
                    r.invalid = 1'b1;
                end else if (cnt > last) begin
                    cnt       = last;
                    r.invalid = 1'b1;
                end
                count_to_date(cnt, ry, rm, rd);
                r.year  = ry[YEAR_W-1:0];
                r.month = rm[MONTH_W-1:0];
                r.day   = rd[DAY_W-1:0];
            end
        end else begin
            if (!date_ok(ya, ma, da) || !date_ok(yb, mb, db)) begin
                r.invalid = 1'b1;
            end else begin
                diff         = day_number(ya, ma, da) - day_number(yb, mb, db);
                r.difference = diff[DIFF_W-1:0];
                r.greater    = diff > 0;
                r.less       = diff < 0;
                r.equal      = diff == 0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        date_result_t got;
        date_result_t want;
        string        bad;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_date_op(date_op_t'(i_s_tuser), i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.year       = i_m_tdata[OUT_YR_LO +: YEAR_W];
                got.month      = i_m_tdata[OUT_MO_LO +: MONTH_W];
                got.day        = i_m_tdata[OUT_DY_LO +: DAY_W];
                got.difference = i_m_tdata[OUT_DIFF_LO +: DIFF_W];
                got.greater    = i_m_tdata[OUT_GT];
                got.less       = i_m_tdata[OUT_LT];
                got.equal      = i_m_tdata[OUT_EQ];
                got.invalid    = i_m_tuser[0];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    bad  = "";
                    if (got.year != want.year)             bad = {bad, " year"};
                    if (got.month != want.month)           bad = {bad, " month"};
                    if (got.day != want.day)               bad = {bad, " day"};
                    if (got.difference != want.difference) bad = {bad, " difference"};
                    if (got.greater != want.greater)       bad = {bad, " greater"};
                    if (got.less != want.less)             bad = {bad, " less"};
                    if (got.equal != want.equal)           bad = {bad, " equal"};
                    if (got.invalid != want.invalid)       bad = {bad, " invalid"};
                    if (bad != "") begin
                        report_mismatch($sformatf(
                            "result %0d:%s; got %0d-%0d-%0d d=%0d g%0b l%0b e%0b i%0b, %s",
                            result_count, bad, got.year, got.month, got.day,
                            $signed(got.difference), got.greater, got.less, got.equal,
                            got.invalid,
                            $sformatf("want %0d-%0d-%0d d=%0d g%0b l%0b e%0b i%0b",
                                      want.year, want.month, want.day,
                                      $signed(want.difference), want.greater, want.less,
                                      want.equal, want.invalid)));
                    end
                end
                result_count++;
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== tb/gregorian_date_add_diff_core_tb.sv =====
`timescale 1ns / 1ps

module gregorian_date_add_diff_core_tb;
    import gdad_pkg::*;
    import gdad_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 116;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int STALL_CYCLES    = 4000;
    localparam int DRAIN_CYCLES    = 1500;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [0:0]              m_tuser;
    int                      fail_count;
    int                      pending;
    int                      cycle_count = 0;
    logic                    steady;
    logic                    hold_output;
    logic                    stall_trigger;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    gregorian_date_add_diff_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    gregorian_date_add_diff_checker date_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        m_tready <= !hold_output && (steady || $urandom_range(0, 99) >= 34);
    end

    // long output back-pressure so the core fills up and stalls its input
    initial begin
        hold_output <= 1'b0;
        wait (stall_trigger === 1'b1);
        @(posedge i_clk);
        hold_output <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(input date_op_t op, input int unsigned ya, input int unsigned ma,
                                input int unsigned da, input int unsigned yb,
                                input int unsigned mb, input int unsigned db, input int ofs);
        logic [IN_TDATA_W-1:0] word;
        word                             = '0;
        word[IN_YA_LO +: YEAR_W]         = ya[YEAR_W-1:0];
        word[IN_MA_LO +: MONTH_W]        = ma[MONTH_W-1:0];
        word[IN_DA_LO +: DAY_W]          = da[DAY_W-1:0];
        word[IN_YB_LO +: YEAR_W]         = yb[YEAR_W-1:0];
        word[IN_MB_LO +: MONTH_W]        = mb[MONTH_W-1:0];
        word[IN_DB_LO +: DAY_W]          = db[DAY_W-1:0];
        word[IN_OFF_LO +: OFFSET_WIDTH]  = ofs[OFFSET_WIDTH-1:0];
        s_tdata  <= word;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 4))
            0: begin
                return $urandom_range(0, 3);
            end
            1: begin
                return $urandom_range(9996, 9999);
            end
            default: begin
                return $urandom_range(0, YEAR_MAX);
            end
        endcase
    endfunction

    function automatic int unsigned pick_day(int unsigned y, int unsigned m);
        int unsigned len;
        len = int'(month_length(y, m));
        if ($urandom_range(0, 99) < 15) begin
            return len;
        end
        return $urandom_range(1, len);
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return int'($urandom);
            end
            4, 5, 6: begin
                return int'($urandom_range(0, 80000)) - 40000;
            end
            default: begin
                return int'($urandom_range(0, 800)) - 400;
            end
        endcase
    endfunction

    initial begin
        int unsigned ya, ma, da, yb, mb, db;
        int          ofs;
        date_op_t    op;
        int unsigned kind;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_ADD;
        steady        <= 1'b0;
        stall_trigger <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leap years, century rules and month or year borrow
        send_request(OP_ADD, 2024, 2, 28, 0, 1, 1, 1);
        send_request(OP_ADD, 1900, 2, 28, 0, 1, 1, 1);
        send_request(OP_ADD, 2000, 2, 29, 0, 1, 1, 365);
        send_request(OP_ADD, 2023, 3, 1, 0, 1, 1, -1);
        send_request(OP_ADD, 2023, 1, 1, 0, 1, 1, -1);
        send_request(OP_ADD, 1, 12, 31, 0, 0, 0, 0);
        // saturation at both ends of the calendar
        send_request(OP_ADD, 0, 1, 1, 0, 1, 1, -1);
        send_request(OP_ADD, 9999, 12, 31, 0, 1, 1, 1);
        send_request(OP_ADD, 9999, 12, 31, 0, 1, 1, -524288);
        send_request(OP_ADD, 0, 1, 1, 9999, 12, 31, 524287);
        send_request(OP_ADD, 9999, 1, 1, 0, 1, 1, 524287);
        // bad input dates
        send_request(OP_ADD, 16383, 15, 31, 16383, 15, 31, -1);
        send_request(OP_ADD, 2023, 0, 10, 0, 1, 1, 5);
        send_request(OP_ADD, 2023, 13, 10, 0, 1, 1, 5);
        send_request(OP_ADD, 2023, 4, 31, 0, 1, 1, 5);
        send_request(OP_ADD, 2023, 2, 29, 0, 1, 1, 5);
        send_request(OP_ADD, 2023, 5, 0, 0, 1, 1, 5);
        // compare and difference
        send_request(OP_DIFF, 9999, 12, 31, 0, 1, 1, 0);
        send_request(OP_DIFF, 0, 1, 1, 9999, 12, 31, 0);
        send_request(OP_DIFF, 2000, 2, 29, 2000, 2, 29, 0);
        send_request(OP_DIFF, 2001, 3, 1, 2000, 2, 29, -524288);
        send_request(OP_DIFF, 2023, 6, 15, 2023, 6, 31, 0);
        send_request(OP_DIFF, 10000, 1, 1, 2023, 1, 1, 7);
        send_request(OP_DIFF, 2100, 2, 29, 2400, 2, 29, 0);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 30) stall_trigger <= 1'b1;
            if (n == 70) steady <= 1'b1;
            if (n == 100) steady <= 1'b0;
            if (n == 115) drain_results();
            op   = date_op_t'($urandom_range(0, 1));
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // raw field noise, mostly bad dates
                ya  = $urandom_range(0, 16383);
                ma  = $urandom_range(0, 15);
                da  = $urandom_range(0, 31);
                yb  = $urandom_range(0, 16383);
                mb  = $urandom_range(0, 15);
                db  = $urandom_range(0, 31);
                ofs = int'($urandom);
            end else begin
                ya = pick_year();
                ma = $urandom_range(1, 12);
                da = pick_day(ya, ma);
                if (kind < 30) begin
                    yb = ya;
                    mb = ma;
                    db = da;
                end else begin
                    if (kind < 55) begin
                        yb = ya + $urandom_range(0, 6);
                        yb = (yb < 3) ? 0 : yb - 3;
                        if (yb > YEAR_MAX) yb = YEAR_MAX;
                    end else begin
                        yb = pick_year();
                    end
                    mb = $urandom_range(1, 12);
                    db = pick_day(yb, mb);
                end
                ofs = pick_offset();
            end
            send_request(op, ya, ma, da, yb, mb, db, ofs);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
